>>> rtl/nnc_pkg.sv
// ----------------------------------------------------------------------------
// nnc_pkg
// Shared types and constants for the nearest neighbor classifier.
// ----------------------------------------------------------------------------
package nnc_pkg;

  localparam int MAX_INSTANCES_DEF   = 1024;
  localparam int MAX_FEATURES_DEF    = 64;
  localparam int VALUE_BITS          = 16;
  localparam int CFG_W               = 7;
  localparam int FEATURE_COUNT_RESET = 4;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef struct packed {
    op_t                          operation;
    logic signed [VALUE_BITS-1:0] feature_value;
    logic [7:0]                   class_label;
    logic [9:0]                   query_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] predicted_class;
    logic [9:0] echoed_index;
    logic       no_neighbor;
    logic       bad_index;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic scan_step;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic scan_last;
    logic pipe_idle;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/nnc_ram.sv
// ----------------------------------------------------------------------------
// nnc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/nnc_ctrl.sv
// ----------------------------------------------------------------------------
// nnc_ctrl
// Sequencer for the classifier: takes transactions, runs the neighbor scan,
// waits for the distance pipeline to drain and hands off the result.
// ----------------------------------------------------------------------------
module nnc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nnc_pkg::op_t       operation,
  input  nnc_pkg::dp_status_t sts,
  output nnc_pkg::ctrl_cmd_t cmd
);

  import nnc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && (operation == OP_CLASSIFY)) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = sts.skip ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_idle) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.take      = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.publish   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_CHECK: begin
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_DRAIN: begin
      end
      S_DONE: begin
        cmd.publish = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/nnc_datapath.sv
// ----------------------------------------------------------------------------
// nnc_datapath
// Instance stores, load bookkeeping, scan address counters, the squared
// distance pipeline, the running minimum and the result register.
// ----------------------------------------------------------------------------
module nnc_datapath #(
  parameter int MAX_INSTANCES = 1024,
  parameter int MAX_FEATURES  = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [nnc_pkg::CFG_W-1:0]   cfg_data,
  input  nnc_pkg::in_item_t           in_data,
  input  nnc_pkg::ctrl_cmd_t          cmd,
  output nnc_pkg::dp_status_t         sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output nnc_pkg::out_item_t          out_data
);

  import nnc_pkg::*;

  localparam int INST_W = $clog2(MAX_INSTANCES);
  localparam int TOT_W  = $clog2(MAX_INSTANCES + 1);
  localparam int FEAT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int ADDR_W = INST_W + FEAT_W;
  localparam int FDEPTH = 1 << ADDR_W;
  localparam int VB     = VALUE_BITS;
  localparam int SQ_W   = 2 * VB;
  localparam int ACC_W  = SQ_W + FEAT_W;

  // Index of the last active feature slot, with the register clamped to
  // the range one to MAX_FEATURES.
  function automatic logic [FEAT_W-1:0] last_feature(input logic [CFG_W-1:0] v);
    logic [31:0] n;
    n = 32'(v);
    if (n == 32'd0) begin
      n = 32'd1;
    end else if (n > 32'(MAX_FEATURES)) begin
      n = 32'(MAX_FEATURES);
    end
    return FEAT_W'(n - 32'd1);
  endfunction

  // Load bookkeeping
  logic [TOT_W-1:0]  total;
  logic [FEAT_W-1:0] pos;
  logic [FEAT_W-1:0] nf_last;
  logic              full;
  logic              load_wr;
  logic              label_wr;

  // Query and scan counters
  logic [9:0]        q_idx;
  logic [INST_W-1:0] q_inst;
  logic [INST_W-1:0] in_q_inst;
  logic              bad;
  logic              none;
  logic [INST_W-1:0] j;
  logic [INST_W-1:0] last_j;
  logic [FEAT_W-1:0] k;
  logic [INST_W:0]   j_inc;
  logic [INST_W:0]   j_inc2;
  logic [INST_W-1:0] j_next;

  // Distance pipeline
  logic [VB-1:0]     a_rd;
  logic [VB-1:0]     b_rd;
  logic [7:0]        lab_rd;
  logic              v1, first1, last1;
  logic signed [VB:0] dif;
  logic [VB:0]       mag;
  logic [VB-1:0]     d2;
  logic [7:0]        lab2;
  logic              v2, first2, last2;
  logic [SQ_W-1:0]   sq3;
  logic [7:0]        lab3;
  logic              v3, first3, last3;
  logic [ACC_W-1:0]  acc;
  logic [7:0]        lab4;
  logic              done4;
  logic [ACC_W-1:0]  best;
  logic [7:0]        best_label;
  logic              have;

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;

  assign full     = (total == TOT_W'(MAX_INSTANCES));
  assign load_wr  = cmd.take && (in_data.operation == OP_LOAD) && !full;
  assign label_wr = load_wr && (pos == nf_last);
  assign q_inst    = INST_W'(q_idx);
  assign in_q_inst = INST_W'(in_data.query_index);

  assign wr_addr   = {total[INST_W-1:0], pos};
  assign rd_addr_a = {q_inst, k};
  assign rd_addr_b = {j, k};

  // The next neighbor steps over the query instance itself.
  assign j_inc  = {1'b0, j} + (INST_W+1)'(1);
  assign j_inc2 = {1'b0, j} + (INST_W+1)'(2);
  assign j_next = (INST_W'(j_inc) == q_inst) ? INST_W'(j_inc2) : INST_W'(j_inc);

  // Two copies of the feature store give the query row and the neighbor row
  // in the same cycle.
  nnc_ram #(.WIDTH(VB), .DEPTH(FDEPTH)) u_feat_a (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (wr_addr),
    .wr_data (in_data.feature_value),
    .rd_addr (rd_addr_a),
    .rd_data (a_rd)
  );

  nnc_ram #(.WIDTH(VB), .DEPTH(FDEPTH)) u_feat_b (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (wr_addr),
    .wr_data (in_data.feature_value),
    .rd_addr (rd_addr_b),
    .rd_data (b_rd)
  );

  nnc_ram #(.WIDTH(8), .DEPTH(MAX_INSTANCES)) u_label (
    .clk     (clk),
    .wr_en   (label_wr),
    .wr_addr (total[INST_W-1:0]),
    .wr_data (in_data.class_label),
    .rd_addr (j),
    .rd_data (lab_rd)
  );

  // Store bookkeeping and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= '0;
      pos     <= '0;
      nf_last <= last_feature(CFG_W'(FEATURE_COUNT_RESET));
    end else begin
      if (cmd.take && (in_data.operation == OP_CLEAR)) begin
        total <= '0;
        pos   <= '0;
      end else if (load_wr) begin
        if (pos == nf_last) begin
          total <= total + TOT_W'(1);
          pos   <= '0;
        end else begin
          pos <= pos + FEAT_W'(1);
        end
      end
      if (cfg_valid) begin
        nf_last <= last_feature(cfg_data);
        pos     <= '0;
      end
    end
  end

  // Query capture and scan counters.
  always_ff @(posedge clk) begin
    if (cmd.take && (in_data.operation == OP_CLASSIFY)) begin
      q_idx <= in_data.query_index;
      bad   <= (32'(in_data.query_index) >= 32'(total));
      none  <= (total < TOT_W'(2));
      j     <= (in_q_inst == '0) ? INST_W'(1) : '0;
      k     <= '0;
      if (in_q_inst == INST_W'(total - TOT_W'(1))) begin
        last_j <= INST_W'(total - TOT_W'(2));
      end else begin
        last_j <= INST_W'(total - TOT_W'(1));
      end
    end else if (cmd.scan_step) begin
      if (k == nf_last) begin
        k <= '0;
        j <= j_next;
      end else begin
        k <= k + FEAT_W'(1);
      end
    end
  end

  // Distance pipeline: read, absolute difference, square, accumulate, minimum.
  always_comb begin
    dif = $signed({a_rd[VB-1], a_rd}) - $signed({b_rd[VB-1], b_rd});
    mag = dif[VB] ? (VB+1)'(0) - (VB+1)'(dif) : (VB+1)'(dif);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      done4 <= 1'b0;
      have  <= 1'b0;
    end else begin
      v1    <= cmd.scan_step;
      v2    <= v1;
      v3    <= v2;
      done4 <= v3 && last3;
      if (cmd.take) begin
        have <= 1'b0;
      end else if (done4 && (!have || (acc < best))) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    first1 <= (k == '0);
    last1  <= (k == nf_last);
    d2     <= mag[VB-1:0];
    lab2   <= lab_rd;
    first2 <= first1;
    last2  <= last1;
    sq3    <= d2 * d2;
    lab3   <= lab2;
    first3 <= first2;
    last3  <= last2;
    lab4   <= lab3;
    if (v3) begin
      acc <= first3 ? ACC_W'(sq3) : acc + ACC_W'(sq3);
    end
    // Strictly smaller only, so the lowest-numbered neighbor keeps a tie.
    if (done4 && (!have || (acc < best))) begin
      best       <= acc;
      best_label <= lab4;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data.predicted_class <= (bad || none) ? 8'd0 : best_label;
      out_data.echoed_index    <= q_idx;
      out_data.no_neighbor     <= none;
      out_data.bad_index       <= bad;
    end
  end

  always_comb begin
    sts.skip      = bad || none;
    sts.scan_last = (j == last_j) && (k == nf_last);
    sts.pipe_idle = !v1 && !v2 && !v3 && !done4;
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

>>> rtl/nearest_neighbor_classifier.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_classifier
// Leave-one-out one-nearest-neighbor classifier on squared Euclidean distance.
// ----------------------------------------------------------------------------
// Load and clear transactions return nothing; a load appends one feature, and
// the label rides with an instance's last feature. A classify transaction
// with N stored instances and F active features scans the N-1 other
// instances: the scan reads one query feature and one neighbor feature per
// cycle from two copies of the feature store, followed by a five-stage
// distance pipeline that must drain before the result is posted. When the
// index is out of range or fewer than two instances are stored, the scan is
// skipped and the result comes back with predicted_class zero. The stores
// need no clearing after reset. Feature slots never written (after
// feature_count is raised) read back as arbitrary values.
module nearest_neighbor_classifier #(
  parameter int MAX_INSTANCES = nnc_pkg::MAX_INSTANCES_DEF,
  parameter int MAX_FEATURES  = nnc_pkg::MAX_FEATURES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [nnc_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  nnc_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output nnc_pkg::out_item_t        out_data
);

  import nnc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  nnc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (in_data.operation),
    .sts       (sts),
    .cmd       (cmd)
  );

  nnc_datapath #(
    .MAX_INSTANCES (MAX_INSTANCES),
    .MAX_FEATURES  (MAX_FEATURES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> test/nnc_result_check.sv
// ----------------------------------------------------------------------------
// nnc_result_check
// Watches the configuration, item and result channels of the nearest neighbor
// classifier. It keeps its own copy of the instance store, works out the
// answer to every classify transaction when it is accepted, and compares each
// result that leaves the block, field by field, with the oldest answer held.
// ----------------------------------------------------------------------------
module nnc_result_check (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [nnc_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  nnc_pkg::in_item_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  nnc_pkg::out_item_t        out_data,
  output int                        mismatches,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import nnc_pkg::*;

  localparam int INST_DEPTH = MAX_INSTANCES_DEF;
  localparam int FEAT_DEPTH = MAX_FEATURES_DEF;

  logic signed [VALUE_BITS-1:0] feature_mem [INST_DEPTH][FEAT_DEPTH];
  logic [7:0]                   label_mem [INST_DEPTH];
  int                           stored_total;
  int                           load_slot;
  logic [CFG_W-1:0]             count_reg;
  out_item_t                    pending_answers[$];

  initial mismatches = 0;

  function automatic int active_width(input logic [CFG_W-1:0] count);
    if (count == 0) return 1;
    if (count > FEAT_DEPTH) return FEAT_DEPTH;
    return int'(count);
  endfunction

  // Leave-one-out search over the stored instances by squared distance.
  function automatic out_item_t classify_query(input logic [9:0] query);
    out_item_t        res;
    int               nf;
    bit               found;
    longint unsigned  best;
    longint unsigned  sq_sum;
    longint           diff;
    nf                  = active_width(count_reg);
    res.predicted_class = '0;
    res.echoed_index    = query;
    res.no_neighbor     = (stored_total < 2);
    res.bad_index       = (int'(query) >= stored_total);
    found               = 1'b0;
    best                = 0;
    if (!res.no_neighbor && !res.bad_index) begin
      for (int j = 0; j < stored_total; j++) begin
        if (j == int'(query)) continue;
        sq_sum = 0;
        // With 16-bit features the 64-bit sum can never saturate.
        for (int k = 0; k < nf; k++) begin
          diff = longint'(feature_mem[query][k]) - longint'(feature_mem[j][k]);
          if (diff < 0) diff = -diff;
          sq_sum += longint'(diff * diff);
        end
        // Strictly smaller only, so the lowest index wins a tie.
        if (!found || sq_sum < best) begin
          found               = 1'b1;
          best                = sq_sum;
          res.predicted_class = label_mem[j];
        end
      end
    end
    return res;
  endfunction

  task automatic take_item(input in_item_t item);
    int nf;
    nf = active_width(count_reg);
    case (item.operation)
      OP_LOAD: begin
        // A full store ignores loads.
        if (stored_total < INST_DEPTH) begin
          feature_mem[stored_total][load_slot] = item.feature_value;
          load_slot++;
          if (load_slot >= nf) begin
            label_mem[stored_total] = item.class_label;
            stored_total++;
            load_slot = 0;
          end
        end
      end
      OP_CLASSIFY: pending_answers.push_back(classify_query(item.query_index));
      OP_CLEAR: begin
        stored_total = 0;
        load_slot    = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      stored_total = 0;
      load_slot    = 0;
      count_reg    = CFG_W'(FEATURE_COUNT_RESET);
      pending_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: class %0d index %0d none %0b bad %0b",
                   $time, out_data.predicted_class, out_data.echoed_index,
                   out_data.no_neighbor, out_data.bad_index);
        end else begin
          want = pending_answers.pop_front();
          if (out_data.predicted_class !== want.predicted_class ||
              out_data.echoed_index !== want.echoed_index ||
              out_data.no_neighbor !== want.no_neighbor ||
              out_data.bad_index !== want.bad_index) begin
            mismatches++;
            $display("%0t: mismatch: expected %s, got %s", $time,
                     $sformatf("class %0d index %0d none %0b bad %0b",
                               want.predicted_class, want.echoed_index,
                               want.no_neighbor, want.bad_index),
                     $sformatf("class %0d index %0d none %0b bad %0b",
                               out_data.predicted_class, out_data.echoed_index,
                               out_data.no_neighbor, out_data.bad_index));
          end
        end
      end
      // Writing the count also restarts the instance being loaded.
      if (cfg_valid && cfg_ready) begin
        count_reg = cfg_data;
        load_slot = 0;
      end
      if (in_valid && in_ready) take_item(in_data);
    end
    outstanding = pending_answers.size();
  end

endmodule

>>> test/tb_nearest_neighbor_classifier.sv
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_classifier
// Drives the classifier with directed and random load, classify, clear and
// no-op transactions under several feature counts and idling patterns, and
// takes the verdict from the result checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import nnc_pkg::*;

  localparam int INST_DEPTH   = MAX_INSTANCES_DEF;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  int               mismatches;
  int               outstanding;

  logic hold_req   = 1'b0;
  int   hold_left  = 0;
  int   send_idle  = 0;
  int   recv_stall = 0;

  // Bookkeeping for choosing legal stimulus.
  int stored_count = 0;
  int fill_slot    = 0;
  int width_now    = FEATURE_COUNT_RESET;
  int width_kept   = FEATURE_COUNT_RESET;
  int items_sent   = 0;

  nearest_neighbor_classifier uut (.*);

  nnc_result_check monitor (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic in_item_t make_item(input op_t op, input logic [15:0] value,
                                         input logic [7:0] lbl, input logic [9:0] query);
    in_item_t item;
    item.operation     = op;
    item.feature_value = value;
    item.class_label   = lbl;
    item.query_index   = query;
    return item;
  endfunction

  function automatic logic [15:0] pick_value();
    // Small values make equal distances, and so ties, likely.
    if ($urandom_range(2) == 0) return 16'($urandom_range(6)) - 16'd3;
    return 16'($urandom);
  endfunction

  task automatic send(input in_item_t item);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    case (item.operation)
      OP_LOAD: begin
        if (stored_count < INST_DEPTH) begin
          items_sent++;
          fill_slot++;
          if (fill_slot >= width_now) begin
            stored_count++;
            fill_slot = 0;
          end
        end
      end
      OP_CLASSIFY: items_sent++;
      OP_CLEAR: begin
        items_sent++;
        stored_count = 0;
        fill_slot    = 0;
        width_kept   = width_now;
      end
      default: ;
    endcase
  endtask

  task automatic load_value(input logic [15:0] value, input logic [7:0] lbl);
    send(make_item(OP_LOAD, value, lbl, 10'($urandom)));
  endtask

  task automatic classify(input logic [9:0] query);
    send(make_item(OP_CLASSIFY, 16'($urandom), 8'($urandom), query));
  endtask

  task automatic clear_store();
    send(make_item(OP_CLEAR, 16'($urandom), 8'($urandom), 10'($urandom)));
  endtask

  // Mostly stored instances, now and then an index past the end.
  task automatic classify_some();
    if (stored_count != 0 && $urandom_range(7) != 0)
      classify(10'($urandom_range(stored_count - 1)));
    else
      classify(10'($urandom));
  endtask

  task automatic load_instance(input logic [7:0] lbl);
    int target;
    target = stored_count + 1;
    while (stored_count < target && stored_count < INST_DEPTH)
      load_value(pick_value(), (fill_slot == width_now - 1) ? lbl : 8'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    width_now = (value == 0) ? 1 : (value > MAX_FEATURES_DEF) ? MAX_FEATURES_DEF : int'(value);
    fill_slot = 0;
    // Stored instances hold only width_kept features, so a wider count
    // needs an empty store before anything is classified.
    if (stored_count != 0 && width_now > width_kept) clear_store();
    else if (stored_count == 0 || width_now < width_kept) width_kept = width_now;
  endtask

  task automatic random_traffic(input int count);
    int goal;
    int pick;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if (stored_count >= 20) clear_store();
        else load_instance(8'($urandom));
      end else if (pick < 80) begin
        classify_some();
      end else if (pick < 88) begin
        // Leave an instance half loaded; a later load finishes it.
        repeat ($urandom_range(width_now - 1)) load_value(pick_value(), 8'($urandom));
      end else if (pick < 94) begin
        clear_store();
      end else begin
        send(make_item(OP_NOP, 16'($urandom), 8'($urandom), 10'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset count of four features.
    classify(10'd0);
    load_value(16'h7FFF, 8'd9);
    load_value(16'h8000, 8'd9);
    load_value(16'h0000, 8'd9);
    load_value(16'h0001, 8'd255);
    classify(10'd0);
    classify(10'd1023);
    load_value(16'h8000, 8'd200);
    load_value(16'h7FFF, 8'd200);
    load_value(16'hFFFF, 8'd200);
    load_value(16'h0000, 8'd0);
    classify(10'd0);
    classify(10'd1);
    load_value(16'h8000, 8'd1);
    load_value(16'h7FFF, 8'd1);
    load_value(16'hFFFF, 8'd1);
    load_value(16'h0000, 8'd7);
    // Instances one and two are at the same distance; one must win.
    classify(10'd0);
    load_value(16'h1234, 8'd3);
    load_value(16'hEDCB, 8'd3);
    // The half-loaded instance is neither a query nor a neighbor.
    classify(10'd3);
    send(make_item(OP_NOP, 16'hFFFF, 8'hFF, 10'h3FF));
    clear_store();
    classify(10'd0);

    // A count of zero acts as one.
    write_count(CFG_W'(0));
    repeat (3) load_instance(8'($urandom));
    classify(10'd0);
    classify(10'd2);
    classify(10'd3);

    // Counts above the store width act as the widest.
    write_count(CFG_W'(127));
    repeat (3) load_instance(8'($urandom));
    classify(10'd0);
    classify(10'd1);
    classify(10'd2);
    classify(10'd5);
    write_count(CFG_W'(64));
    load_instance(8'($urandom));
    classify(10'd3);
    classify(10'd0);

    // Fill the store at one feature per instance; further loads are dropped.
    send_idle  = 0;
    recv_stall = 0;
    write_count(CFG_W'(1));
    while (stored_count < INST_DEPTH) load_instance(8'($urandom));
    repeat (3) load_value(pick_value(), 8'($urandom));
    classify(10'd0);
    classify(10'd1023);
    classify(10'($urandom));
    clear_store();

    // Random traffic under the idling patterns.
    write_count(CFG_W'($urandom_range(2, 8)));
    random_traffic(25);

    send_idle = 62;
    write_count(CFG_W'($urandom_range(1, 8)));
    random_traffic(25);

    send_idle  = 0;
    recv_stall = 62;
    write_count(CFG_W'($urandom_range(1, 6)));
    random_traffic(12);
    // Hold the receiver off while classify transactions keep arriving.
    in_valid <= 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (8) classify_some();
    random_traffic(13);

    send_idle  = 11;
    recv_stall = 11;
    write_count(CFG_W'($urandom_range(2, 8)));
    random_traffic(12);
    settle();
    random_traffic(13);

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/nnc_pkg.sv
rtl/nnc_ram.sv
rtl/nnc_ctrl.sv
rtl/nnc_datapath.sv
rtl/nearest_neighbor_classifier.sv
test/nnc_result_check.sv
test/tb_nearest_neighbor_classifier.sv
